// ===== sv/eurw_pkg.sv =====
// Shared constants, codes and types of the reservation wheel.
package eurw_pkg;
    localparam int WHEEL_DEPTH = 32;
    localparam int MAX_PENDING = 8;
    localparam int SLOT_W = $clog2(WHEEL_DEPTH);
    localparam int LEN_W = $clog2(WHEEL_DEPTH + 1);
    localparam int PIDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int FILL_W = $clog2(MAX_PENDING + 1);
    localparam int UNITS_W = 5;
    localparam int START_W = 5;
    localparam int RLEN_W = 6;
    localparam int ACC_W = UNITS_W + FILL_W;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_CHECK = 2'd1;
    localparam logic [1:0] CMD_RESERVE = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    localparam logic [0:0] REG_UNIT_COUNT = 1'b0;
    localparam logic [0:0] REG_WHEEL_LENGTH = 1'b1;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_ACC_CLR = 3'd1;
    localparam logic [2:0] OP_ACC_ADD = 3'd2;
    localparam logic [2:0] OP_FOLD = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic               use_acc;
        logic               fold_en;
        logic [SLOT_W-1:0]  cmod;
        logic [LEN_W-1:0]   wlen;
        logic [START_W-1:0] win_start;
        logic [RLEN_W:0]    win_end;
        logic [UNITS_W-1:0] units;
        logic [UNITS_W-1:0] unit_count;
    } cell_ctrl_t;
endpackage

// ===== sv/exec_unit_reservation_wheel.sv =====
// Top level: command sequencer, pending list and the row of wheel cells.
// One transaction at a time. Every command first brings the current slot below
// the wheel length by repeated subtraction (none unless wheel_length was shrunk);
// check and tick then walk the pending reservations, one per cycle through the
// cell row, before the result is formed. The next transaction is taken once
// the result has been delivered.
module exec_unit_reservation_wheel (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // units[4:0], start_req[9:5], length[15:10]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // can_reserve[0], error[1], zero[7:2]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD = 2'd1;
    localparam logic [1:0] ST_PEND = 2'd2;
    localparam logic [1:0] ST_FIN = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [eurw_pkg::UNITS_W-1:0]    unit_count_reg;
    logic [5:0]                      wheel_length_reg;
    logic [eurw_pkg::SLOT_W-1:0]     cur_reg, cur_next, cmod_reg, cmod_next;
    logic [eurw_pkg::FILL_W-1:0]     fill_reg, fill_next, k_reg, k_next;
    logic [1:0]                      cmd_reg;
    logic [eurw_pkg::UNITS_W-1:0]    units_reg;
    logic [eurw_pkg::START_W-1:0]    start_reg;
    logic [eurw_pkg::RLEN_W-1:0]     len_reg;
    logic                            err_reg, err_next;
    logic                            m_valid_reg;
    logic [1:0]                      m_data_reg;
    logic [eurw_pkg::UNITS_W-1:0]    p_units_reg [eurw_pkg::MAX_PENDING];
    logic [eurw_pkg::START_W-1:0]    p_start_reg [eurw_pkg::MAX_PENDING];
    logic [eurw_pkg::RLEN_W-1:0]     p_len_reg [eurw_pkg::MAX_PENDING];
    logic [eurw_pkg::LEN_W-1:0]      wlen;
    logic [eurw_pkg::RLEN_W:0]       req_end, pend_end;
    logic [eurw_pkg::PIDX_W-1:0]     k_idx, fill_idx;
    logic                            req_bad, pend_bad;
    logic                            s_fire;
    logic [eurw_pkg::LEN_W-1:0]      cur_inc;
    eurw_pkg::cell_ctrl_t            ctrl;
    logic [eurw_pkg::WHEEL_DEPTH:0]  chain;

    assign s_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {6'd0, m_data_reg};
    assign k_idx = k_reg[eurw_pkg::PIDX_W-1:0];
    assign fill_idx = fill_reg[eurw_pkg::PIDX_W-1:0];

    always_comb begin
        if (wheel_length_reg < 6'd2) begin
            wlen = eurw_pkg::LEN_W'(2);
        end else if (7'(wheel_length_reg) > 7'(eurw_pkg::WHEEL_DEPTH)) begin
            wlen = eurw_pkg::LEN_W'(eurw_pkg::WHEEL_DEPTH);
        end else begin
            wlen = eurw_pkg::LEN_W'(wheel_length_reg);
        end
        req_end = (eurw_pkg::RLEN_W + 1)'(start_reg) + (eurw_pkg::RLEN_W + 1)'(len_reg);
        pend_end = (eurw_pkg::RLEN_W + 1)'(p_start_reg[k_idx])
                   + (eurw_pkg::RLEN_W + 1)'(p_len_reg[k_idx]);
        req_bad = req_end > (eurw_pkg::RLEN_W + 1)'(wlen);
        pend_bad = pend_end > (eurw_pkg::RLEN_W + 1)'(wlen);
        cur_inc = eurw_pkg::LEN_W'(cmod_reg) + eurw_pkg::LEN_W'(1);
    end

    always_comb begin
        ctrl.op = eurw_pkg::OP_NONE;
        ctrl.use_acc = 1'b0;
        ctrl.fold_en = 1'b0;
        ctrl.cmod = cmod_reg;
        ctrl.wlen = wlen;
        ctrl.win_start = start_reg;
        ctrl.win_end = req_end;
        ctrl.units = units_reg;
        ctrl.unit_count = unit_count_reg;
        case (state_reg)
            ST_MOD: ctrl.op = eurw_pkg::OP_ACC_CLR;
            ST_PEND: begin
                ctrl.win_start = p_start_reg[k_idx];
                ctrl.win_end = pend_end;
                ctrl.units = p_units_reg[k_idx];
                if (k_reg < fill_reg) begin
                    ctrl.op = (cmd_reg == eurw_pkg::CMD_TICK) ? eurw_pkg::OP_FOLD
                                                               : eurw_pkg::OP_ACC_ADD;
                end
                ctrl.fold_en = !pend_bad && chain[eurw_pkg::WHEEL_DEPTH];
            end
            ST_FIN: begin
                ctrl.use_acc = 1'b1;
                if (cmd_reg == eurw_pkg::CMD_TICK) ctrl.op = eurw_pkg::OP_CLEAR;
            end
            default: ;
        endcase
    end

    assign chain[0] = 1'b1;
    for (genvar i = 0; i < eurw_pkg::WHEEL_DEPTH; i++) begin : g_cell
        eurw_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (eurw_pkg::SLOT_W'(i)),
            .ctrl     (ctrl),
            .ok_in    (chain[i]),
            .ok_out   (chain[i+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        cur_next = cur_reg;
        cmod_next = cmod_reg;
        fill_next = fill_reg;
        k_next = k_reg;
        err_next = err_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_MOD;
                    cmod_next = cur_reg;
                    err_next = 1'b0;
                end
            end
            ST_MOD: begin
                k_next = '0;
                if (eurw_pkg::LEN_W'(cmod_reg) >= wlen) begin
                    cmod_next = eurw_pkg::SLOT_W'(eurw_pkg::LEN_W'(cmod_reg) - wlen);
                end else if (cmd_reg == eurw_pkg::CMD_CHECK
                             || cmd_reg == eurw_pkg::CMD_TICK) begin
                    state_next = ST_PEND;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_PEND: begin
                if (k_reg < fill_reg) begin
                    k_next = k_reg + 1'b1;
                    if (cmd_reg == eurw_pkg::CMD_TICK
                        && (pend_bad || !chain[eurw_pkg::WHEEL_DEPTH])) begin
                        err_next = 1'b1;
                    end
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                state_next = ST_IDLE;
                case (cmd_reg)
                    eurw_pkg::CMD_CLEAR: fill_next = '0;
                    eurw_pkg::CMD_CHECK: err_next = req_bad;
                    eurw_pkg::CMD_RESERVE: begin
                        if (req_bad || fill_reg >= eurw_pkg::FILL_W'(eurw_pkg::MAX_PENDING)) begin
                            err_next = 1'b1;
                        end else begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    default: begin
                        cur_next = (cur_inc == wlen) ? '0 : eurw_pkg::SLOT_W'(cur_inc);
                    end
                endcase
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            unit_count_reg <= 5'd4;
            wheel_length_reg <= 6'd32;
            cur_reg <= '0;
            fill_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cur_reg <= cur_next;
            fill_reg <= fill_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == eurw_pkg::REG_UNIT_COUNT) begin
                    unit_count_reg <= cfg_data[4:0];
                end else begin
                    wheel_length_reg <= cfg_data;
                end
            end
            if (state_reg == ST_FIN) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        cmod_reg <= cmod_next;
        k_reg <= k_next;
        err_reg <= err_next;
        if (s_fire) begin
            cmd_reg <= s_tuser;
            units_reg <= s_tdata[4:0];
            start_reg <= s_tdata[9:5];
            len_reg <= s_tdata[15:10];
        end
        if (state_reg == ST_FIN && cmd_reg == eurw_pkg::CMD_RESERVE && !req_bad
            && fill_reg < eurw_pkg::FILL_W'(eurw_pkg::MAX_PENDING)) begin
            p_units_reg[fill_idx] <= units_reg;
            p_start_reg[fill_idx] <= start_reg;
            p_len_reg[fill_idx] <= len_reg;
        end
        if (state_reg == ST_FIN) begin
            m_data_reg[1] <= err_next;
            m_data_reg[0] <= (cmd_reg == eurw_pkg::CMD_CHECK) && !req_bad
                             && chain[eurw_pkg::WHEEL_DEPTH];
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= eurw_pkg::FILL_W'(eurw_pkg::MAX_PENDING))
        else $error("pending fill beyond list depth");
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PEND |-> k_reg <= fill_reg)
        else $error("pending walk past fill");
    a_result_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[0] && m_data_reg[1]))
        else $error("room reported together with error");
    a_tick_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && cmd_reg == eurw_pkg::CMD_TICK)
        |=> eurw_pkg::LEN_W'(cur_reg) < $past(wlen))
        else $error("current slot past wheel length after tick");
endmodule

// ===== sv/eurw_cell.sv =====
// One wheel slot: committed count, pending sum and room test in the chain.
module eurw_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [eurw_pkg::SLOT_W-1:0]  cell_idx,
    input  eurw_pkg::cell_ctrl_t         ctrl,
    input  logic                         ok_in,
    output logic                         ok_out
);
    logic [eurw_pkg::UNITS_W-1:0] count_reg, count_next;
    logic [eurw_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic                         active, inwin, fits;
    logic [eurw_pkg::LEN_W-1:0]   cyc;
    logic [eurw_pkg::ACC_W+1:0]   need;

    always_comb begin
        active = {1'b0, cell_idx} < ctrl.wlen;
        if (cell_idx >= ctrl.cmod) begin
            cyc = {1'b0, cell_idx - ctrl.cmod};
        end else begin
            cyc = {1'b0, cell_idx} + ctrl.wlen - {1'b0, ctrl.cmod};
        end
        inwin = active && (cyc >= {1'b0, ctrl.win_start})
                && ({1'b0, cyc} < ctrl.win_end);
        need = (eurw_pkg::ACC_W + 2)'(count_reg) + (eurw_pkg::ACC_W + 2)'(ctrl.units)
               + (ctrl.use_acc ? (eurw_pkg::ACC_W + 2)'(acc_reg) : '0);
        fits = need <= (eurw_pkg::ACC_W + 2)'(ctrl.unit_count);
        ok_out = ok_in && (!inwin || fits);
        count_next = count_reg;
        acc_next = acc_reg;
        case (ctrl.op)
            eurw_pkg::OP_ACC_CLR: acc_next = '0;
            eurw_pkg::OP_ACC_ADD: if (inwin) acc_next = acc_reg + eurw_pkg::ACC_W'(ctrl.units);
            eurw_pkg::OP_FOLD: if (inwin && ctrl.fold_en) count_next = count_reg + ctrl.units;
            eurw_pkg::OP_CLEAR: if (cell_idx == ctrl.cmod) count_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        acc_reg <= acc_next;
    end
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the execution-unit reservation wheel.
`timescale 1ns / 1ps

module tb;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [4:0] units;
        logic [4:0] start_req;
        logic [5:0] length;
    } wheel_req_t;

    typedef struct packed {
        logic can_reserve;
        logic error;
    } wheel_rsp_t;

    typedef struct {
        wheel_req_t req;
        logic       typed;
        wheel_rsp_t rsp;
    } table_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [5:0]  cfg_data;

    exec_unit_reservation_wheel DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // predictor state
    logic [4:0] units_avail;
    logic [5:0] wheel_len_reg;
    int         booked[eurw_pkg::WHEEL_DEPTH];
    int         cur_slot;
    int         pend_units[eurw_pkg::MAX_PENDING];
    int         pend_start[eurw_pkg::MAX_PENDING];
    int         pend_len[eurw_pkg::MAX_PENDING];
    int         pend_fill;

    wheel_rsp_t expected_rsp[$];
    int         failures;
    int         idle_cycles;
    int         send_idle_pct;
    int         recv_idle_pct;

    function automatic int active_len();
        int l;
        l = wheel_len_reg;
        if (l < 2) l = 2;
        if (l > eurw_pkg::WHEEL_DEPTH) l = eurw_pkg::WHEEL_DEPTH;
        return l;
    endfunction

    function automatic int wheel_index(int ahead, int l);
        return ((cur_slot % l) + ahead) % l;
    endfunction

    function automatic int pending_load(int cyc);
        int sum;
        sum = 0;
        for (int k = 0; k < pend_fill; k++)
            if (pend_start[k] <= cyc && cyc < pend_start[k] + pend_len[k])
                sum += pend_units[k];
        return sum;
    endfunction

    function automatic wheel_rsp_t book_request(wheel_req_t r);
        wheel_rsp_t o;
        int l, s, n, u;
        bit fits;
        o = '0;
        l = active_len();
        s = r.start_req;
        n = r.length;
        u = r.units;
        case (r.cmd)
            eurw_pkg::CMD_CLEAR: pend_fill = 0;
            eurw_pkg::CMD_CHECK: begin
                if (s + n > l) o.error = 1'b1;
                else begin
                    o.can_reserve = 1'b1;
                    for (int p = 0; p < n; p++)
                        if (booked[wheel_index(s + p, l)] + pending_load(s + p) + u
                            > units_avail) begin
                            o.can_reserve = 1'b0;
                            break;
                        end
                end
            end
            eurw_pkg::CMD_RESERVE: begin
                if (s + n > l || pend_fill >= eurw_pkg::MAX_PENDING) o.error = 1'b1;
                else begin
                    pend_units[pend_fill] = u;
                    pend_start[pend_fill] = s;
                    pend_len[pend_fill] = n;
                    pend_fill++;
                end
            end
            default: begin
                for (int k = 0; k < pend_fill; k++) begin
                    fits = (pend_start[k] + pend_len[k] <= l);
                    for (int p = 0; fits && p < pend_len[k]; p++)
                        if (booked[wheel_index(pend_start[k] + p, l)] + pend_units[k]
                            > units_avail) fits = 0;
                    if (!fits) begin
                        o.error = 1'b1;
                        continue;
                    end
                    for (int p = 0; p < pend_len[k]; p++)
                        booked[wheel_index(pend_start[k] + p, l)] += pend_units[k];
                end
                booked[wheel_index(0, l)] = 0;
                cur_slot = wheel_index(1, l);
            end
        endcase
        return o;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            idle_cycles <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t watchdog expired", $time);
                $display("Test completed with failures");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t unexpected result %b", $time, m_tdata);
                    failures++;
                end else begin
                    if (m_tdata[0] !== expected_rsp[0].can_reserve) begin
                        $display("%0t can_reserve exp %b got %b", $time,
                                 expected_rsp[0].can_reserve, m_tdata[0]);
                        failures++;
                    end
                    if (m_tdata[1] !== expected_rsp[0].error) begin
                        $display("%0t error exp %b got %b", $time,
                                 expected_rsp[0].error, m_tdata[1]);
                        failures++;
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        $display("%0t pad exp 0 got %h", $time, m_tdata[7:2]);
                        failures++;
                    end
                    void'(expected_rsp.pop_front());
                end
            end
        end
    end

    task automatic send_item(wheel_req_t r, logic typed, wheel_rsp_t t);
        wheel_rsp_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.cmd;
        s_tdata <= {r.length, r.start_req, r.units};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = book_request(r);
        if (typed && p !== t) begin
            $display("%0t table row exp %b predictor %b", $time, t, p);
            failures++;
        end
        expected_rsp = {expected_rsp, (typed ? t : p)};
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [5:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == eurw_pkg::REG_UNIT_COUNT) units_avail = val[4:0];
        else wheel_len_reg = val;
    endtask

    function automatic wheel_req_t rand_req();
        wheel_req_t r;
        int sel;
        int l;
        l = active_len();
        sel = $urandom_range(99);
        if (sel < 8) r.cmd = eurw_pkg::CMD_CLEAR;
        else if (sel < 40) r.cmd = eurw_pkg::CMD_CHECK;
        else if (sel < 75) r.cmd = eurw_pkg::CMD_RESERVE;
        else r.cmd = eurw_pkg::CMD_TICK;
        r.units = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(4));
        if ($urandom_range(9) == 0) begin
            r.start_req = 5'($urandom);
            r.length = 6'($urandom);
        end else begin
            r.start_req = 5'($urandom_range(l - 1 > 31 ? 31 : l - 1));
            r.length = 6'($urandom_range(l - r.start_req > 6 ? 6 : l - r.start_req));
        end
        return r;
    endfunction

    table_row_t directed[$];

    function automatic table_row_t row(logic [1:0] c, int u, int s, int n,
                                       logic typed, logic ok, logic err);
        table_row_t t;
        t.req = '{cmd: c, units: 5'(u), start_req: 5'(s), length: 6'(n)};
        t.typed = typed;
        t.rsp = '{can_reserve: ok, error: err};
        return t;
    endfunction

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        failures = 0;
        send_idle_pct = 19;
        recv_idle_pct = 72;
        units_avail = 5'd4;
        wheel_len_reg = 6'd32;
        foreach (booked[i]) booked[i] = 0;
        cur_slot = 0;
        pend_fill = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed = '{
            row(eurw_pkg::CMD_CHECK, 4, 0, 32, 1, 1, 0),
            row(eurw_pkg::CMD_CHECK, 5, 0, 1, 1, 0, 0),
            row(eurw_pkg::CMD_CHECK, 0, 31, 2, 1, 0, 1),
            row(eurw_pkg::CMD_CHECK, 31, 31, 63, 1, 0, 1),
            row(eurw_pkg::CMD_CHECK, 0, 0, 0, 1, 1, 0),
            row(eurw_pkg::CMD_RESERVE, 0, 1, 32, 1, 0, 1),
            row(eurw_pkg::CMD_RESERVE, 3, 0, 4, 0, 0, 0),
            row(eurw_pkg::CMD_RESERVE, 2, 2, 4, 0, 0, 0),
            row(eurw_pkg::CMD_CHECK, 1, 0, 2, 0, 0, 0),
            row(eurw_pkg::CMD_CHECK, 1, 4, 3, 0, 0, 0),
            row(eurw_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0),
            row(eurw_pkg::CMD_RESERVE, 1, 0, 1, 0, 0, 0),
            row(eurw_pkg::CMD_RESERVE, 1, 0, 1, 0, 0, 0),
            row(eurw_pkg::CMD_RESERVE, 1, 0, 1, 0, 0, 0),
            row(eurw_pkg::CMD_RESERVE, 1, 0, 1, 0, 0, 0),
            row(eurw_pkg::CMD_RESERVE, 1, 0, 1, 0, 0, 0),
            row(eurw_pkg::CMD_RESERVE, 1, 0, 1, 0, 0, 0),
            row(eurw_pkg::CMD_RESERVE, 1, 0, 1, 0, 0, 0),
            row(eurw_pkg::CMD_RESERVE, 1, 0, 1, 1, 0, 1),
            row(eurw_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0),
            row(eurw_pkg::CMD_CLEAR, 31, 31, 63, 1, 0, 0),
            row(eurw_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0)
        };
        foreach (directed[i]) send_item(directed[i].req, directed[i].typed, directed[i].rsp);

        write_reg(eurw_pkg::REG_UNIT_COUNT, 6'd16);
        write_reg(eurw_pkg::REG_WHEEL_LENGTH, 6'd5);
        send_item('{cmd: eurw_pkg::CMD_CHECK, units: 5'd16, start_req: 5'd0, length: 6'd5},
                  1'b0, '0);
        send_item('{cmd: eurw_pkg::CMD_TICK, units: 5'd0, start_req: 5'd0, length: 6'd0},
                  1'b0, '0);
        write_reg(eurw_pkg::REG_WHEEL_LENGTH, 6'd0);
        write_reg(eurw_pkg::REG_UNIT_COUNT, 6'd1);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 2) begin
                send_idle_pct = 72;
                recv_idle_pct = 19;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: begin
                    write_reg(eurw_pkg::REG_UNIT_COUNT, 6'd4);
                    write_reg(eurw_pkg::REG_WHEEL_LENGTH, 6'd32);
                end
                1: begin
                    write_reg(eurw_pkg::REG_UNIT_COUNT, 6'd1);
                    write_reg(eurw_pkg::REG_WHEEL_LENGTH, 6'd2);
                end
                2: begin
                    write_reg(eurw_pkg::REG_UNIT_COUNT, 6'd16);
                    write_reg(eurw_pkg::REG_WHEEL_LENGTH, 6'd63);
                end
                3: begin
                    write_reg(eurw_pkg::REG_UNIT_COUNT, 6'd31);
                    write_reg(eurw_pkg::REG_WHEEL_LENGTH, 6'd7);
                end
                4: begin
                    write_reg(eurw_pkg::REG_UNIT_COUNT, 6'd3);
                    write_reg(eurw_pkg::REG_WHEEL_LENGTH, 6'd12);
                end
                default: begin
                    write_reg(eurw_pkg::REG_UNIT_COUNT, 6'd0);
                    write_reg(eurw_pkg::REG_WHEEL_LENGTH, 6'd1);
                end
            endcase
            for (int i = 0; i < 125; i++) begin
                if (i == 60) begin
                    s_tvalid <= 1'b0;
                    while (expected_rsp.size() != 0) @(posedge aclk);
                end
                send_item(rand_req(), 1'b0, '0);
            end
        end

        drain();
        if (failures == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== exec_unit_reservation_wheel.f =====
sv/eurw_pkg.sv
sv/eurw_cell.sv
sv/exec_unit_reservation_wheel.sv
tb/tb.sv
